### sv/tm_pkg.sv
// tm_pkg: shared types and codes for the Turing machine step engine.
// Holds command, status and move codes, the rule word layout and the
// sequencer state type. No dependencies.
package tm_pkg;

    // default sizes
    localparam int TM_TAPE_CELLS = 128;
    localparam int TM_NUM_STATES = 16;
    localparam int TM_SLOTS      = 8;

    // command codes
    localparam logic [2:0] CMD_LOAD  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_START = 3'd2;
    localparam logic [2:0] CMD_STEP  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    // status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_STEP    = 3'd1;
    localparam logic [2:0] STAT_HALT    = 3'd2;
    localparam logic [2:0] STAT_NOMATCH = 3'd3;
    localparam logic [2:0] STAT_EDGE    = 3'd4;

    // head moves; anything else halts
    localparam logic [1:0] MV_RIGHT = 2'd0;
    localparam logic [1:0] MV_LEFT  = 2'd1;

    typedef struct packed {
        logic       valid;
        logic [7:0] rd_sym;
        logic [7:0] wr_sym;
        logic [1:0] mv;
        logic [3:0] nxt;
    } t_rule;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_TAPE,
        S_SCAN
    } t_state;

endpackage

### sv/turing_machine_step_engine.sv
// turing_machine_step_engine: top level of the single-tape Turing machine.
// Depends on tm_pkg, tm_ram (tape and rule memories) and tm_seq.
//
// Usage:
//   Command channel: drive i_command and its fields with start high; the
//   transaction is taken at a rising edge where start is high and busy low.
//   Commands: load rule, write tape cell, start machine, step, read cell.
//   Result channel: o_valid is high for exactly one cycle with status, head
//   cell, machine state, symbol and halted flag. The receiver cannot stall,
//   so the result must be captured in that cycle.
//   Load, write, start and unknown commands finish in the execute state,
//   as does a step while halted or from an unused state; a tape read of
//   a valid cell passes through the tape state; a step reads the cell
//   under the head, then scans k rule slots (k from 1 to SLOTS_PER_STATE).
//   The step time is set by the rule scan: one slot per cycle through the
//   rule memory read port and a single symbol comparator.
//   One command at a time; busy is low again in the cycle o_valid shows, so
//   a new command may be issued then.
//   Reset (i_rst_n low, synchronous) clears head, state and halted flag and
//   then runs a clearing pass of max(TAPE_CELLS, NUM_STATES*SLOTS_PER_STATE)
//   addresses (128 by default) that zeroes the tape and invalidates all rules;
//   busy stays high during the pass.
module turing_machine_step_engine
    import tm_pkg::*;
#(
    parameter int TAPE_CELLS      = TM_TAPE_CELLS,
    parameter int NUM_STATES      = TM_NUM_STATES,
    parameter int SLOTS_PER_STATE = TM_SLOTS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_command,
    input  logic [3:0] i_rule_state,
    input  logic [2:0] i_rule_slot,
    input  logic [7:0] i_read_symbol,
    input  logic [7:0] i_write_symbol,
    input  logic [1:0] i_move,
    input  logic [3:0] i_next_state,
    input  logic [6:0] i_cell_req,
    output logic       busy,
    output logic       o_valid,
    output logic [2:0] o_status,
    output logic [6:0] o_head_cell,
    output logic [3:0] o_machine_state,
    output logic [7:0] o_symbol,
    output logic       o_is_halted
);

    localparam int TAW   = $clog2(TAPE_CELLS);
    localparam int RULES = NUM_STATES * SLOTS_PER_STATE;
    localparam int RAW   = $clog2(RULES);

    // tape memory port
    logic           tape_we;
    logic [TAW-1:0] tape_waddr;
    logic [7:0]     tape_wdata;
    logic [TAW-1:0] tape_raddr;
    logic [7:0]     tape_rdata;

    // rule memory port
    logic           rule_we;
    logic [RAW-1:0] rule_waddr;
    t_rule          rule_wdata;
    logic [RAW-1:0] rule_raddr;
    t_rule          rule_rdata;

    // tape: one byte per cell
    tm_ram #(
        .DEPTH (TAPE_CELLS),
        .WIDTH (8)
    ) u_tape (
        .i_clk   (i_clk),
        .i_we    (tape_we),
        .i_waddr (tape_waddr),
        .i_wdata (tape_wdata),
        .i_raddr (tape_raddr),
        .o_rdata (tape_rdata)
    );

    // rule table: state-major, slot-minor
    tm_ram #(
        .DEPTH (RULES),
        .WIDTH ($bits(t_rule))
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (rule_we),
        .i_waddr (rule_waddr),
        .i_wdata (rule_wdata),
        .i_raddr (rule_raddr),
        .o_rdata (rule_rdata)
    );

    // sequencer, machine registers and slot comparator
    tm_seq #(
        .TAPE_CELLS      (TAPE_CELLS),
        .NUM_STATES      (NUM_STATES),
        .SLOTS_PER_STATE (SLOTS_PER_STATE)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_command       (i_command),
        .i_rule_state    (i_rule_state),
        .i_rule_slot     (i_rule_slot),
        .i_read_symbol   (i_read_symbol),
        .i_write_symbol  (i_write_symbol),
        .i_move          (i_move),
        .i_next_state    (i_next_state),
        .i_cell_req      (i_cell_req),
        .busy            (busy),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_head_cell     (o_head_cell),
        .o_machine_state (o_machine_state),
        .o_symbol        (o_symbol),
        .o_is_halted     (o_is_halted),
        .o_tape_we       (tape_we),
        .o_tape_waddr    (tape_waddr),
        .o_tape_wdata    (tape_wdata),
        .o_tape_raddr    (tape_raddr),
        .i_tape_rdata    (tape_rdata),
        .o_rule_we       (rule_we),
        .o_rule_waddr    (rule_waddr),
        .o_rule_wdata    (rule_wdata),
        .o_rule_raddr    (rule_raddr),
        .i_rule_rdata    (rule_rdata)
    );

endmodule

### sv/tm_ram.sv
// tm_ram: single write port, single read port memory with registered read.
// Used for the tape and the rule table. No package dependency.
module tm_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tm_seq.sv
// tm_seq: command sequencer with the shared rule compare unit.
// Drives the tape and rule memories (tm_ram); depends on tm_pkg.
module tm_seq
    import tm_pkg::*;
#(
    parameter int TAPE_CELLS      = TM_TAPE_CELLS,
    parameter int NUM_STATES      = TM_NUM_STATES,
    parameter int SLOTS_PER_STATE = TM_SLOTS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        start,
    input  logic [2:0]                                  i_command,
    input  logic [3:0]                                  i_rule_state,
    input  logic [2:0]                                  i_rule_slot,
    input  logic [7:0]                                  i_read_symbol,
    input  logic [7:0]                                  i_write_symbol,
    input  logic [1:0]                                  i_move,
    input  logic [3:0]                                  i_next_state,
    input  logic [6:0]                                  i_cell_req,
    output logic                                        busy,
    output logic                                        o_valid,
    output logic [2:0]                                  o_status,
    output logic [6:0]                                  o_head_cell,
    output logic [3:0]                                  o_machine_state,
    output logic [7:0]                                  o_symbol,
    output logic                                        o_is_halted,
    // tape memory
    output logic                                        o_tape_we,
    output logic [$clog2(TAPE_CELLS)-1:0]               o_tape_waddr,
    output logic [7:0]                                  o_tape_wdata,
    output logic [$clog2(TAPE_CELLS)-1:0]               o_tape_raddr,
    input  logic [7:0]                                  i_tape_rdata,
    // rule memory
    output logic                                        o_rule_we,
    output logic [$clog2(NUM_STATES*SLOTS_PER_STATE)-1:0] o_rule_waddr,
    output t_rule                                       o_rule_wdata,
    output logic [$clog2(NUM_STATES*SLOTS_PER_STATE)-1:0] o_rule_raddr,
    input  t_rule                                       i_rule_rdata
);

    localparam int TAW   = $clog2(TAPE_CELLS);
    localparam int RULES = NUM_STATES * SLOTS_PER_STATE;
    localparam int RAW   = $clog2(RULES);
    localparam int SLW   = (SLOTS_PER_STATE > 1) ? $clog2(SLOTS_PER_STATE) : 1;
    localparam int CLR_N = (TAPE_CELLS > RULES) ? TAPE_CELLS : RULES;
    localparam int CW    = $clog2(CLR_N);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_clr, n_clr;
    logic [TAW-1:0] r_head, n_head;
    logic [3:0]     r_mstate, n_mstate;
    logic           r_halted, n_halted;
    logic           r_valid, n_valid;
    logic [2:0]     r_status, n_status;
    logic [7:0]     r_sym, n_sym;
    logic [SLW-1:0] r_slot, n_slot;
    logic [7:0]     r_under, n_under;

    // latched command transaction
    logic [2:0] r_cmd;
    logic [3:0] r_rstate;
    logic [2:0] r_rslot;
    logic [7:0] r_rsym;
    logic [7:0] r_wsym;
    logic [1:0] r_mv;
    logic [3:0] r_nxt;
    logic [6:0] r_cell;

    logic accept;
    logic cell_ok;
    logic load_ok;
    logic state_ok;
    logic hit;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign cell_ok = (32'(r_cell) < 32'(TAPE_CELLS));
    assign load_ok = (32'(r_rstate) < 32'(NUM_STATES)) &&
                     (32'(r_rslot) < 32'(SLOTS_PER_STATE));
    assign state_ok = (32'(r_mstate) < 32'(NUM_STATES));
    // shared compare unit: one rule slot per cycle
    assign hit = i_rule_rdata.valid && (i_rule_rdata.rd_sym == r_under);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_head   <= '0;
            r_mstate <= '0;
            r_halted <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_head   <= n_head;
            r_mstate <= n_mstate;
            r_halted <= n_halted;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_sym    <= n_sym;
        r_slot   <= n_slot;
        r_under  <= n_under;
        if (accept) begin
            r_cmd    <= i_command;
            r_rstate <= i_rule_state;
            r_rslot  <= i_rule_slot;
            r_rsym   <= i_read_symbol;
            r_wsym   <= i_write_symbol;
            r_mv     <= i_move;
            r_nxt    <= i_next_state;
            r_cell   <= i_cell_req;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_head       = r_head;
        n_mstate     = r_mstate;
        n_halted     = r_halted;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_sym        = r_sym;
        n_slot       = r_slot;
        n_under      = r_under;
        o_tape_we    = 1'b0;
        o_tape_waddr = r_head;
        o_tape_wdata = i_rule_rdata.wr_sym;
        o_tape_raddr = r_head;
        o_rule_we    = 1'b0;
        o_rule_waddr = RAW'(32'(r_rstate) * SLOTS_PER_STATE + 32'(r_rslot));
        o_rule_wdata = '{valid: 1'b1, rd_sym: r_rsym, wr_sym: r_wsym,
                         mv: r_mv, nxt: r_nxt};

        unique case (r_state)
            S_CLEAR: begin
                o_tape_we    = (32'(r_clr) < 32'(TAPE_CELLS));
                o_tape_waddr = TAW'(r_clr);
                o_tape_wdata = '0;
                o_rule_we    = (32'(r_clr) < 32'(RULES));
                o_rule_waddr = RAW'(r_clr);
                o_rule_wdata = '0;
                n_clr        = r_clr + 1'b1;
                if (r_clr == CW'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = STAT_OK;
                n_sym    = '0;
                priority if (r_cmd == CMD_LOAD) begin
                    o_rule_we = load_ok;
                    n_valid   = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_cmd == CMD_WRITE) begin
                    o_tape_we    = cell_ok;
                    o_tape_waddr = TAW'(r_cell);
                    o_tape_wdata = r_wsym;
                    n_sym        = cell_ok ? r_wsym : 8'd0;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end else if (r_cmd == CMD_START) begin
                    n_head   = cell_ok ? TAW'(r_cell) : TAW'(TAPE_CELLS - 1);
                    n_mstate = '0;
                    n_halted = 1'b0;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (r_cmd == CMD_STEP) begin
                    if (r_halted) begin
                        n_status = STAT_HALT;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else if (!state_ok) begin
                        n_status = STAT_NOMATCH;
                        n_valid  = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        o_tape_raddr = r_head;
                        n_state      = S_TAPE;
                    end
                end else if (r_cmd == CMD_READ) begin
                    o_tape_raddr = TAW'(r_cell);
                    if (cell_ok) begin
                        n_state = S_TAPE;
                    end else begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TAPE: begin
                if (r_cmd == CMD_READ) begin
                    n_status = STAT_OK;
                    n_sym    = i_tape_rdata;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_under = i_tape_rdata;
                    n_slot  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    o_tape_we    = 1'b1;
                    o_tape_waddr = r_head;
                    o_tape_wdata = i_rule_rdata.wr_sym;
                    n_sym        = i_rule_rdata.wr_sym;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                    priority if (i_rule_rdata.mv == MV_RIGHT) begin
                        if (r_head == TAW'(TAPE_CELLS - 1)) begin
                            n_status = STAT_EDGE;
                        end else begin
                            n_head   = r_head + 1'b1;
                            n_mstate = i_rule_rdata.nxt;
                            n_status = STAT_STEP;
                        end
                    end else if (i_rule_rdata.mv == MV_LEFT) begin
                        if (r_head == '0) begin
                            n_status = STAT_EDGE;
                        end else begin
                            n_head   = r_head - 1'b1;
                            n_mstate = i_rule_rdata.nxt;
                            n_status = STAT_STEP;
                        end
                    end else begin
                        n_halted = 1'b1;
                        n_status = STAT_HALT;
                    end
                end else if (r_slot == SLW'(SLOTS_PER_STATE - 1)) begin
                    n_status = STAT_NOMATCH;
                    n_sym    = '0;
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // rule read follows the slot about to be examined
        o_rule_raddr = RAW'(32'(r_mstate) * SLOTS_PER_STATE + 32'(n_slot));
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_head_cell     = 7'(r_head);
    assign o_machine_state = r_mstate;
    assign o_symbol        = r_sym;
    assign o_is_halted     = r_halted;

endmodule

### sv/tm_chk.sv
// tm_chk: port-level checks for turing_machine_step_engine, bound to it.
// Depends on tm_pkg for status codes.
module tm_chk
    import tm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       i_busy,
    input logic       i_valid,
    input logic [2:0] i_status,
    input logic [6:0] i_head_cell,
    input logic [3:0] i_machine_state,
    input logic       i_is_halted
);

    // an accepted command keeps the engine busy and yields no result at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !i_busy |=> i_busy && !i_valid)
        else $error("accepted command did not occupy the engine");

    // results only appear when the engine is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> !i_busy)
        else $error("result shown while busy");

    // machine registers move only as a command completes
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_busy |=> $stable(i_head_cell) && $stable(i_machine_state) &&
                    $stable(i_is_halted))
        else $error("machine state changed while idle");

    // halt status agrees with the halted flag; a STEP result never has it set
    a_halt_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == STAT_HALT || i_status == STAT_STEP) |->
            (i_is_halted == (i_status == STAT_HALT)))
        else $error("halted flag disagrees with status");

endmodule

bind turing_machine_step_engine tm_chk u_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_start         (start),
    .i_busy          (busy),
    .i_valid         (o_valid),
    .i_status        (o_status),
    .i_head_cell     (o_head_cell),
    .i_machine_state (o_machine_state),
    .i_is_halted     (o_is_halted)
);
